/* rtl/alsd_pkg.sv */
// Package for the addressable LED strip driver: payload types, codes and defaults.
package alsd_pkg;

  localparam int MaxLedsDefault   = 256;
  localparam int DutyWidthDefault = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ALL   = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  localparam logic [2:0] CFG_LED_COUNT     = 3'd0;
  localparam logic [2:0] CFG_DUTY_ONE      = 3'd1;
  localparam logic [2:0] CFG_DUTY_ZERO     = 3'd2;
  localparam logic [2:0] CFG_RESET_PERIODS = 3'd3;
  localparam logic [2:0] CFG_AUTO_UPDATE   = 3'd4;
  localparam logic [2:0] CFG_USE_WHITE     = 3'd5;

  localparam logic [8:0]  LedCountReset     = 9'd1;
  localparam logic [15:0] DutyOneReset      = 16'd0;
  localparam logic [15:0] DutyZeroReset     = 16'd0;
  localparam logic [7:0]  ResetPeriodsReset = 8'd1;
  localparam logic        AutoUpdateReset   = 1'b1;
  localparam logic        UseWhiteReset     = 1'b0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        busy_res;
    logic        frame_done;
  } res_item_t;

  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic res_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_TAIL  = 4'b0100,
    PH_RESET = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    CS_CLEAR = 4'b0001,
    CS_READY = 4'b0010,
    CS_FILL  = 4'b0100,
    CS_EMIT  = 4'b1000
  } ctrl_state_t;

endpackage

/* rtl/alsd_ctrl.sv */
// Controller state machine: sequences clearing, fills, command beats and tick results.
module alsd_ctrl import alsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic [1:0] cmd_op,
  output logic       cmd_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  ctrl
);

  ctrl_state_t state, state_next;

  always_comb begin
    state_next      = state;
    ctrl            = '0;
    cmd_stall       = 1'b1;
    unique case (state)
      CS_CLEAR, CS_FILL: begin
        ctrl.sweep_step = 1'b1;
        if (status.sweep_last) state_next = CS_READY;
      end
      CS_READY: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctrl.accept = 1'b1;
          if (cmd_op == OP_TICK) state_next = CS_EMIT;
          else if (cmd_op == OP_ALL) state_next = CS_FILL;
        end
      end
      CS_EMIT: begin
        if (status.res_free) begin
          ctrl.emit  = 1'b1;
          state_next = CS_READY;
        end
      end
      default: state_next = CS_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/alsd_datapath.sv */
// Datapath: configuration registers, colour memory, frame counters and result register.
module alsd_datapath import alsd_pkg::*; #(
  parameter int MAX_LEDS   = MaxLedsDefault,
  parameter int DUTY_WIDTH = DutyWidthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_item_t  cmd,
  input  ctrl_cmd_t  ctrl,
  output dp_status_t status,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic       res_valid,
  input  logic       res_stall,
  output res_item_t  res
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [15:0] DutyMask =
    (DUTY_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << DUTY_WIDTH) - 32'd1);

  logic [8:0]  strip_len;
  logic [15:0] duty_one;
  logic [15:0] duty_zero;
  logic [7:0]  reset_periods;
  logic        auto_frame;
  logic        use_white;

  logic [31:0] color_mem [MAX_LEDS];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [AW-1:0] sweep_cnt;
  logic [AW-1:0] sweep_end;
  logic [31:0]   sweep_data;

  phase_t     phase, phase_next;
  logic [8:0] led_position, led_position_next;
  logic [4:0] bit_position, bit_position_next;
  logic [7:0] reset_count, reset_count_next;
  logic       update_pending, update_pending_next;
  res_item_t  res_next;

  logic [8:0]  count;
  logic [8:0]  pos;
  logic [5:0]  bpl;
  logic [31:0] packed_color;
  logic        idx_ok;
  logic        do_write;
  logic [8:0]  write_idx;
  logic [4:0]  bp_inc;
  logic [9:0]  lp_inc;
  logic [7:0]  rc_inc;
  logic [7:0]  rlen;

  always_comb begin
    count = strip_len;
    if (count == 9'd0) count = 9'd1;
    if (32'(strip_len) > MAX_LEDS) count = 9'(MAX_LEDS);
  end

  assign bpl          = use_white ? 6'd32 : 6'd24;
  assign packed_color = {cmd.green, cmd.red, cmd.blue, cmd.white};
  assign idx_ok       = {1'b0, cmd.led_index} < count;
  assign pos          = (led_position < count) ? led_position : count - 9'd1;
  assign rd_addr      = AW'(pos);

  assign status.sweep_last = sweep_cnt == sweep_end;
  assign status.res_free   = !res_valid || !res_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_cnt;
    wr_data = sweep_data;
    if (ctrl.sweep_step) begin
      wr_en = 1'b1;
    end else if (ctrl.accept && cmd.op == OP_WRITE && idx_ok) begin
      wr_en   = 1'b1;
      wr_addr = AW'(cmd.led_index);
      wr_data = packed_color;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) color_mem[wr_addr] <= wr_data;
    rd_data <= color_mem[rd_addr];
  end

  always_comb begin
    phase_next          = phase;
    led_position_next   = led_position;
    bit_position_next   = bit_position;
    reset_count_next    = reset_count;
    update_pending_next = update_pending;
    res_next            = '0;
    do_write            = 1'b0;
    write_idx           = {1'b0, cmd.led_index};
    bp_inc              = bit_position + 5'd1;
    lp_inc              = {1'b0, led_position} + 10'd1;
    rc_inc              = reset_count + 8'd1;
    rlen                = (reset_periods == 8'd0) ? 8'd1 : reset_periods;

    if (ctrl.accept) begin
      unique case (cmd.op)
        OP_WRITE: do_write = idx_ok;
        OP_ALL: begin
          do_write  = 1'b1;
          write_idx = 9'd0;
        end
        OP_START: begin
          if (phase == PH_IDLE) begin
            led_position_next   = '0;
            bit_position_next   = '0;
            reset_count_next    = '0;
            update_pending_next = 1'b0;
            phase_next          = PH_DATA;
          end
        end
        default: ;
      endcase
      if (do_write && auto_frame) begin
        if (phase == PH_IDLE) begin
          led_position_next   = '0;
          bit_position_next   = '0;
          reset_count_next    = '0;
          update_pending_next = 1'b0;
          phase_next          = PH_DATA;
        end else if (write_idx <= led_position) begin
          update_pending_next = 1'b1;
        end
      end
    end

    if (ctrl.emit) begin
      unique case (phase)
        PH_DATA: begin
          res_next.duty     = (rd_data[~bit_position] ? duty_one : duty_zero) & DutyMask;
          res_next.busy_res = 1'b1;
          bit_position_next = bp_inc;
          if (bp_inc == 5'd0 || {1'b0, bp_inc} >= bpl) begin
            bit_position_next = '0;
            if (lp_inc >= {1'b0, count}) begin
              led_position_next = count;
              phase_next        = PH_TAIL;
            end else begin
              led_position_next = lp_inc[8:0];
            end
          end
        end
        PH_TAIL: begin
          res_next.busy_res = 1'b1;
          bit_position_next = bp_inc;
          if (bp_inc == 5'd0 || {1'b0, bp_inc} >= bpl) begin
            bit_position_next = '0;
            reset_count_next  = '0;
            phase_next        = PH_RESET;
          end
        end
        PH_RESET: begin
          res_next.busy_res = 1'b1;
          reset_count_next  = rc_inc;
          if (rc_inc >= rlen || rc_inc == 8'd0) begin
            res_next.frame_done = 1'b1;
            reset_count_next    = '0;
            led_position_next   = '0;
            phase_next          = PH_IDLE;
            if (update_pending) begin
              bit_position_next   = '0;
              update_pending_next = 1'b0;
              phase_next          = PH_DATA;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      led_position   <= '0;
      bit_position   <= '0;
      reset_count    <= '0;
      update_pending <= 1'b0;
      strip_len      <= LedCountReset;
      duty_one       <= DutyOneReset;
      duty_zero      <= DutyZeroReset;
      reset_periods  <= ResetPeriodsReset;
      auto_frame     <= AutoUpdateReset;
      use_white      <= UseWhiteReset;
      sweep_cnt      <= '0;
      sweep_end      <= AW'(MAX_LEDS - 1);
      sweep_data     <= '0;
      res_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      led_position   <= led_position_next;
      bit_position   <= bit_position_next;
      reset_count    <= reset_count_next;
      update_pending <= update_pending_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LED_COUNT:     strip_len     <= cfg_data[8:0];
          CFG_DUTY_ONE:      duty_one      <= cfg_data;
          CFG_DUTY_ZERO:     duty_zero     <= cfg_data;
          CFG_RESET_PERIODS: reset_periods <= cfg_data[7:0];
          CFG_AUTO_UPDATE:   auto_frame    <= cfg_data[0];
          CFG_USE_WHITE:     use_white     <= cfg_data[0];
          default: ;
        endcase
      end
      if (ctrl.accept && cmd.op == OP_ALL) begin
        sweep_cnt  <= '0;
        sweep_end  <= AW'(count - 9'd1);
        sweep_data <= packed_color;
      end else if (ctrl.sweep_step) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
      if (ctrl.emit) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) res <= res_next;
  end

endmodule

/* rtl/addressable_led_strip_driver_core.sv */
// Top level of the addressable LED strip driver: controller and datapath joined.
// After reset all MAX_LEDS words of the colour memory are cleared, during which the command
// channel stalls (configuration writes are taken throughout). A single-LED write or a frame
// start then completes with its accepted beat. For a tick, the beat is taken while the
// colour word of the current LED is read into the memory output register, and the result
// register is loaded in the emit state, later if the previous result is still held there.
// A write-all holds the command channel for one memory write per LED of the effective count.
module addressable_led_strip_driver_core import alsd_pkg::*; #(
  parameter int MAX_LEDS   = MaxLedsDefault,
  parameter int DUTY_WIDTH = DutyWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_item_t   cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_item_t   res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  alsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd.op),
    .cmd_stall (cmd_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  alsd_datapath #(
    .MAX_LEDS   (MAX_LEDS),
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
